// ----- rtl/cag_pkg.sv -----
`default_nettype none

package cag_pkg;

    // Default grid size.
    localparam int unsigned MAX_COLS_DEF = 64;
    localparam int unsigned MAX_ROWS_DEF = 64;

    // Field widths of the request and result channels.
    localparam int unsigned OP_W  = 2;
    localparam int unsigned COL_W = 6;
    localparam int unsigned ROW_W = 6;

    // Configuration port.
    localparam int unsigned CFG_W  = 7;
    localparam int unsigned CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_MAP_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]  CFG_SIZE_RESET = 7'd64;

    // Neighborhood window: 5x5 around the cell, 3x3 for the near count.
    localparam int unsigned WIN  = 5;
    localparam int unsigned HALF = (WIN - 1) / 2;

    // Automaton thresholds.
    localparam int unsigned KEEP_MIN   = 3;
    localparam int unsigned BIRTH_MIN  = 5;
    localparam int unsigned LONELY_MAX = 2;

    localparam logic RULE_CONSERVATIVE = 1'b0;
    localparam logic RULE_SMOOTH       = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_GEN  = 1'b1;

    localparam logic CELL_WALL  = 1'b1;
    localparam logic CELL_FLOOR = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_GEN   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SWEEP,
        ST_STORE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic host_write;
        logic host_read;
        logic gen_start;
        logic load_step;
        logic sweep;
        logic store_row;
        logic read_resp;
        logic gen_resp;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic load_last;
        logic col_last;
        logic row_last;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/cag_in_if.sv -----
`default_nettype none

interface cag_in_if import cag_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             cell_in;
    logic             rule_select;

    modport source (output valid, op, col, row, cell_in, rule_select, input ready);
    modport sink   (input valid, op, col, row, cell_in, rule_select, output ready);
endinterface

`default_nettype wire

// ----- rtl/cag_out_if.sv -----
`default_nettype none

interface cag_out_if import cag_pkg::*; ();
    logic valid;
    logic ready;
    logic result_kind;
    logic cell_out;

    modport source (output valid, result_kind, cell_out, input ready);
    modport sink   (input valid, result_kind, cell_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/cag_ctrl.sv -----
`default_nettype none

module cag_ctrl import cag_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  logic [OP_W-1:0] i_op,
    input  t_status         i_status,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    unique case (i_op)
                        OP_WRITE: begin
                            o_cmd.host_write = 1'b1;
                        end
                        OP_READ: begin
                            o_cmd.host_read = 1'b1;
                            n_state         = ST_READ;
                        end
                        OP_GEN: begin
                            o_cmd.gen_start = 1'b1;
                            n_state         = ST_LOAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (i_status.out_free) begin
                    o_cmd.read_resp = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_LOAD: begin
                o_cmd.load_step = 1'b1;
                if (i_status.load_last) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.col_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store_row = 1'b1;
                n_state = i_status.row_last ? ST_DONE : ST_LOAD;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.gen_resp = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/cag_datapath.sv -----
`default_nettype none

module cag_datapath import cag_pkg::*; #(
    parameter int unsigned MAX_COLS = MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [COL_W-1:0]  i_col,
    input  logic [ROW_W-1:0]  i_row,
    input  logic              i_cell_in,
    input  logic              i_rule_select,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic              o_result_kind,
    output logic              o_cell_out
);

    localparam int unsigned CIW   = $clog2(MAX_COLS);
    localparam int unsigned RIW   = $clog2(MAX_ROWS);
    localparam int unsigned EWW   = $clog2(MAX_COLS + 1);
    localparam int unsigned EHW   = $clog2(MAX_ROWS + 1);
    localparam int unsigned DEPTH = 2 * MAX_ROWS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned EXT   = MAX_COLS + WIN - 1;
    localparam int unsigned SAT_C = (MAX_COLS < 127) ? MAX_COLS : 127;
    localparam int unsigned SAT_R = (MAX_ROWS < 127) ? MAX_ROWS : 127;

    // Configuration and effective map size.
    logic [CFG_W-1:0] r_map_w;
    logic [CFG_W-1:0] r_map_h;
    logic [CFG_W-1:0] clip_w;
    logic [CFG_W-1:0] clip_h;
    logic [EWW-1:0]   eff_w;
    logic [EHW-1:0]   eff_h;
    logic [MAX_COLS-1:0] w_mask;
    logic             host_in_map;

    // Grid memory: one word per row, both banks stacked.
    logic [MAX_COLS-1:0] mem [DEPTH];
    logic [MAX_COLS-1:0] r_rdata;
    logic                mem_re;
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [AW-1:0]       mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;
    logic [MAX_COLS-1:0] mem_wmask;

    logic r_bank;

    // Generation sweep.
    logic [RIW-1:0]      r_row;
    logic [2:0]          r_k;
    logic [CIW-1:0]      r_col;
    logic                r_rule;
    logic                r_ld_valid;
    logic [RIW:0]        ld_sum;
    logic                ld_valid;
    logic [RIW-1:0]      ld_row;
    logic [EXT-1:0]      r_win [WIN];
    logic [EXT-1:0]      pad_row;
    logic [MAX_COLS-1:0] r_orow;

    logic [2:0] row_wide [WIN];
    logic [4:0] sum_wide;
    logic [3:0] sum_near;
    logic [4:0] wide;
    logic [3:0] near;
    logic       center;
    logic       cell_next;

    // Host read.
    logic           r_rd_oob;
    logic [CIW-1:0] r_rd_col;

    // Result register.
    logic r_out_valid;
    logic r_out_kind;
    logic r_out_cell;

    function automatic logic [AW-1:0] addr_of(input logic bank, input logic [RIW-1:0] row);
        logic [AW-1:0] a;
        a = AW'(row);
        if (bank) begin
            a = a + AW'(MAX_ROWS);
        end
        return a;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= CFG_SIZE_RESET;
            r_map_h <= CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAP_WIDTH:  r_map_w <= i_cfg_wdata;
                CFG_MAP_HEIGHT: r_map_h <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A size of zero acts as one; a size above the grid saturates.
    always_comb begin
        clip_w = r_map_w;
        if (r_map_w == '0) begin
            clip_w = CFG_W'(1);
        end else if (r_map_w > CFG_W'(SAT_C)) begin
            clip_w = CFG_W'(SAT_C);
        end
        clip_h = r_map_h;
        if (r_map_h == '0) begin
            clip_h = CFG_W'(1);
        end else if (r_map_h > CFG_W'(SAT_R)) begin
            clip_h = CFG_W'(SAT_R);
        end
    end

    assign eff_w = EWW'(clip_w);
    assign eff_h = EHW'(clip_h);

    always_comb begin
        for (int i = 0; i < MAX_COLS; i++) begin
            w_mask[i] = (32'(i) < 32'(eff_w));
        end
    end

    assign host_in_map = (32'(i_col) < 32'(eff_w)) && (32'(i_row) < 32'(eff_h));

    // Row that the current load step fetches, relative to the output row.
    assign ld_sum   = (RIW+1)'(r_row) + (RIW+1)'(r_k);
    assign ld_valid = (ld_sum >= (RIW+1)'(HALF)) &&
                      (32'(ld_sum) - 32'(HALF) < 32'(eff_h));
    assign ld_row   = RIW'(32'(ld_sum) - 32'(HALF));

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_wmask = '0;
        if (i_cmd.host_read) begin
            mem_re    = 1'b1;
            mem_raddr = addr_of(r_bank, RIW'(i_row));
        end else if (i_cmd.load_step && (r_k < 3'(WIN)) && ld_valid) begin
            mem_re    = 1'b1;
            mem_raddr = addr_of(r_bank, ld_row);
        end
        if (i_cmd.host_write && host_in_map) begin
            mem_we    = 1'b1;
            mem_waddr = addr_of(r_bank, RIW'(i_row));
            mem_wdata = {MAX_COLS{i_cell_in}};
            mem_wmask = MAX_COLS'(1) << CIW'(i_col);
        end else if (i_cmd.store_row) begin
            mem_we    = 1'b1;
            mem_waddr = addr_of(!r_bank, r_row);
            mem_wdata = r_orow;
            mem_wmask = w_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int i = 0; i < MAX_COLS; i++) begin
                if (mem_wmask[i]) begin
                    mem[mem_waddr][i] <= mem_wdata[i];
                end
            end
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Fetched row with the border walls: two columns on each side, and every
    // column beyond the map width. A row outside the map is all walls.
    always_comb begin
        pad_row = '1;
        for (int c = 0; c < MAX_COLS; c++) begin
            pad_row[c + HALF] = !r_ld_valid || !w_mask[c] || r_rdata[c];
        end
    end

    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            row_wide[j] = '0;
            for (int i = 0; i < WIN; i++) begin
                row_wide[j] = row_wide[j] + 3'(r_win[j][i]);
            end
        end
        sum_wide = '0;
        for (int j = 0; j < WIN; j++) begin
            sum_wide = sum_wide + 5'(row_wide[j]);
        end
        sum_near = '0;
        for (int j = HALF - 1; j <= HALF + 1; j++) begin
            sum_near = sum_near + 4'(r_win[j][HALF-1]) + 4'(r_win[j][HALF])
                     + 4'(r_win[j][HALF+1]);
        end
        center = r_win[HALF][HALF];
        wide   = sum_wide - 5'(center);
        near   = sum_near - 4'(center);
        if (center == CELL_WALL) begin
            cell_next = (near >= 4'(KEEP_MIN));
        end else begin
            cell_next = (near >= 4'(BIRTH_MIN)) ||
                        ((r_rule == RULE_CONSERVATIVE) && (wide <= 5'(LONELY_MAX)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_start) begin
            r_row  <= '0;
            r_k    <= '0;
            r_rule <= i_rule_select;
        end
        if (i_cmd.load_step) begin
            if (r_k != 3'd0) begin
                for (int j = 0; j < WIN - 1; j++) begin
                    r_win[j] <= r_win[j+1];
                end
                r_win[WIN-1] <= pad_row;
            end
            if (r_k < 3'(WIN)) begin
                r_ld_valid <= ld_valid;
            end
            if (r_k == 3'(WIN)) begin
                r_k   <= '0;
                r_col <= '0;
            end else begin
                r_k <= r_k + 3'd1;
            end
        end
        if (i_cmd.sweep) begin
            for (int j = 0; j < WIN; j++) begin
                r_win[j] <= {1'b1, r_win[j][EXT-1:1]};
            end
            r_orow[r_col] <= cell_next;
            r_col         <= r_col + CIW'(1);
        end
        if (i_cmd.store_row && !o_status.row_last) begin
            r_row <= r_row + RIW'(1);
        end
        if (i_cmd.host_read) begin
            r_rd_oob <= !host_in_map;
            r_rd_col <= CIW'(i_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.gen_resp) begin
                r_bank <= !r_bank;
            end
            if (i_cmd.read_resp || i_cmd.gen_resp) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_resp) begin
            r_out_kind <= KIND_READ;
            r_out_cell <= r_rd_oob ? CELL_WALL : r_rdata[r_rd_col];
        end else if (i_cmd.gen_resp) begin
            r_out_kind <= KIND_GEN;
            r_out_cell <= CELL_FLOOR;
        end
    end

    assign o_status.out_free  = !r_out_valid || i_rsp_ready;
    assign o_status.load_last = (r_k == 3'(WIN));
    assign o_status.col_last  = (r_col == CIW'(32'(eff_w) - 32'd1));
    assign o_status.row_last  = (r_row == RIW'(32'(eff_h) - 32'd1));

    assign o_rsp_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_cell_out    = r_out_cell;

endmodule

`default_nettype wire

// ----- rtl/cave_automaton_generation.sv -----
// Cave generation automaton over a wall/floor grid of MAX_COLS x MAX_ROWS cells.
// Requests arrive on i_req (valid/ready): op 0 writes one cell, op 2 reads one
// cell, op 1 runs one generation with the rule given by rule_select. Results
// leave on o_rsp (valid/ready) from an output register: read data, or a
// generation-finished marker. Writes give no result; op 3 is dropped.
// A write is done when it is taken and the next request can follow right away.
// A read latches its row, then answers once the output register is free.
// A generation fetches the five rows around each output row through the single
// read port of the row memory, one row a cycle, then walks the row one column
// a cycle through a 5x5 window, then writes the row back, with no new request
// taken meanwhile. The user must set the map size through the configuration
// port only while the block is idle; the block itself does not enforce this.
// Reset selects bank 0 and a 64 x 64 map; the grid holds no defined contents
// until the host writes it. When the receiver stalls, the result stays in the
// output register; writes are still taken, while a read or a generation waits
// for the register to free up before finishing.
`default_nettype none

module cave_automaton_generation import cag_pkg::*; #(
    parameter int unsigned MAX_COLS = MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cag_in_if.sink            i_req,
    cag_out_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    cag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_op        (i_req.op),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cag_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_col         (i_req.col),
        .i_row         (i_req.row),
        .i_cell_in     (i_req.cell_in),
        .i_rule_select (i_req.rule_select),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_result_kind (o_rsp.result_kind),
        .o_cell_out    (o_rsp.cell_out)
    );

endmodule

`default_nettype wire

// ----- rtl/cag_checker.sv -----
`default_nettype none

module cag_checker import cag_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            i_req_ready,
    input logic [OP_W-1:0] i_req_op,
    input logic            i_rsp_valid,
    input logic            i_rsp_ready,
    input logic            i_rsp_kind,
    input logic            i_rsp_cell
);

    logic req_acc;

    assign req_acc = i_req_valid && i_req_ready;

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_kind) && $stable(i_rsp_cell))
        else $error("stalled result changed");

    // A generation-finished result carries a zero cell value.
    a_gen_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_kind == KIND_GEN) |-> (i_rsp_cell == CELL_FLOOR))
        else $error("generation result with nonzero cell");

    // Reads and generations block the request channel while they run.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && ((i_req_op == OP_READ) || (i_req_op == OP_GEN)) |=> !i_req_ready)
        else $error("request taken while busy");

    // With an empty output, read data follows via the read register.
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && (i_req_op == OP_READ) && !i_rsp_valid |=>
            ##1 (i_rsp_valid && (i_rsp_kind == KIND_READ)))
        else $error("read result late or of wrong kind");

endmodule

bind cave_automaton_generation cag_checker u_cag_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_op    (i_req.op),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_kind  (o_rsp.result_kind),
    .i_rsp_cell  (o_rsp.cell_out)
);

`default_nettype wire

// ----- test/tb_cave_automaton_generation.sv -----
`timescale 1ns / 100ps

module tb_cave_automaton_generation;
    import cag_pkg::*;

    localparam int GRID_COLS = MAX_COLS_DEF;
    localparam int GRID_ROWS = MAX_ROWS_DEF;
    localparam int CELLS     = GRID_COLS * GRID_ROWS;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int IDLE_PCT      = 26;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             val;
        logic             rule;
    } t_cave_req;

    typedef struct {
        logic kind;
        logic val;
    } t_cave_rsp;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;

    cag_in_if  req_if ();
    cag_out_if rsp_if ();

    cave_automaton_generation i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow of the block: both banks, the current bank and the map size in use.
    bit        cave [2][CELLS];
    bit        cave_bank = 1'b0;
    int        map_w = GRID_COLS;
    int        map_h = GRID_ROWS;
    t_cave_rsp replies_due [$];

    // Stimulus side: which cells of each bank hold a written value, as seen
    // by the requests queued so far.
    t_cave_req req_backlog [$];
    bit        known [2][CELLS];
    bit        stim_bank = 1'b0;
    int        last_c = 0;
    int        last_r = 0;

    bit req_taken = 1'b0;
    bit steady = 1'b0;
    bit hold_phase = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int fail_count = 0;

    task automatic flag_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    function automatic int clamp_size(int raw, int limit);
        if (raw == 0) return 1;
        if (raw > limit) return limit;
        return raw;
    endfunction

    function automatic bit wall_at(int c, int r);
        if (c < 0 || r < 0 || c >= map_w || r >= map_h) return CELL_WALL;
        return cave[cave_bank][r * GRID_COLS + c];
    endfunction

    function automatic int walls_in(int c, int r, int radius);
        int n;
        n = 0;
        for (int dy = -radius; dy <= radius; dy++) begin
            for (int dx = -radius; dx <= radius; dx++) begin
                if (dx != 0 || dy != 0) n += wall_at(c + dx, r + dy);
            end
        end
        return n;
    endfunction

    // One generation, computed from the current bank into the other one.
    task automatic evolve_grid(logic rule);
        int near_walls;
        int wide_walls;
        bit grown;
        for (int r = 0; r < map_h; r++) begin
            for (int c = 0; c < map_w; c++) begin
                near_walls = walls_in(c, r, 1);
                wide_walls = walls_in(c, r, 2);
                if (wall_at(c, r) == CELL_WALL) begin
                    grown = (near_walls >= KEEP_MIN);
                end else if (rule == RULE_CONSERVATIVE) begin
                    grown = (near_walls >= BIRTH_MIN) || (wide_walls <= LONELY_MAX);
                end else begin
                    grown = (near_walls >= BIRTH_MIN);
                end
                cave[!cave_bank][r * GRID_COLS + c] = grown;
            end
        end
        cave_bank = !cave_bank;
    endtask

    task automatic predict_reply(t_cave_req q);
        t_cave_rsp due;
        case (q.op)
            OP_WRITE: begin
                if (int'(q.col) < map_w && int'(q.row) < map_h)
                    cave[cave_bank][int'(q.row) * GRID_COLS + int'(q.col)] = q.val;
            end
            OP_GEN: begin
                evolve_grid(q.rule);
                due.kind = KIND_GEN;
                due.val  = CELL_FLOOR;
                replies_due.push_back(due);
            end
            OP_READ: begin
                due.kind = KIND_READ;
                due.val  = wall_at(int'(q.col), int'(q.row));
                replies_due.push_back(due);
            end
            default: ;
        endcase
    endtask

    function automatic void push_req(logic [OP_W-1:0] op, int col, int row, bit val, bit rule);
        t_cave_req q;
        q.op   = op;
        q.col  = col[COL_W-1:0];
        q.row  = row[ROW_W-1:0];
        q.val  = val;
        q.rule = rule;
        if (op == OP_WRITE && col < map_w && row < map_h) begin
            known[stim_bank][row * GRID_COLS + col] = 1'b1;
            last_c = col;
            last_r = row;
        end else if (op == OP_GEN) begin
            for (int r = 0; r < map_h; r++)
                for (int c = 0; c < map_w; c++)
                    known[!stim_bank][r * GRID_COLS + c] = 1'b1;
            stim_bank = !stim_bank;
        end
        req_backlog.push_back(q);
    endfunction

    function automatic bit map_ready();
        for (int r = 0; r < map_h; r++)
            for (int c = 0; c < map_w; c++)
                if (!known[stim_bank][r * GRID_COLS + c]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void fill_map(int dens);
        for (int r = 0; r < map_h; r++)
            for (int c = 0; c < map_w; c++)
                if (!known[stim_bank][r * GRID_COLS + c])
                    push_req(OP_WRITE, c, r, $urandom_range(99) < dens, $urandom_range(1));
    endfunction

    // A generation is only queued once every cell of the map holds a value, and
    // a read of an unwritten cell goes to the last written one, else is a write.
    function automatic void random_reqs(int count, int dens);
        int done;
        int pick;
        int c;
        int r;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if ($urandom_range(3) == 0) begin
                c = $urandom_range(GRID_COLS - 1);
                r = $urandom_range(GRID_ROWS - 1);
            end else begin
                c = $urandom_range(map_w - 1);
                r = $urandom_range(map_h - 1);
            end
            if (pick < 5) begin
                push_req(OP_SPARE, $urandom_range(63), $urandom_range(63),
                         $urandom_range(1), $urandom_range(1));
            end else if (pick < 17 && map_ready()) begin
                push_req(OP_GEN, $urandom_range(63), $urandom_range(63),
                         $urandom_range(1), $urandom_range(1));
                done++;
            end else if (pick < 55) begin
                if (c < map_w && r < map_h && !known[stim_bank][r * GRID_COLS + c]) begin
                    c = last_c;
                    r = last_r;
                end
                if (c < map_w && r < map_h && !known[stim_bank][r * GRID_COLS + c])
                    push_req(OP_WRITE, c, r, $urandom_range(99) < dens, $urandom_range(1));
                else
                    push_req(OP_READ, c, r, $urandom_range(1), $urandom_range(1));
                done++;
            end else begin
                push_req(OP_WRITE, c, r, $urandom_range(99) < dens, $urandom_range(1));
                if (c < map_w && r < map_h) done++;
            end
        end
    endfunction

    task automatic set_map(int w_raw, int h_raw);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_addr  = CFG_MAP_WIDTH;
        cfg_wdata = w_raw[CFG_W-1:0];
        @(negedge i_clk);
        cfg_addr  = CFG_MAP_HEIGHT;
        cfg_wdata = h_raw[CFG_W-1:0];
        @(negedge i_clk);
        cfg_we = 1'b0;
        map_w  = clamp_size(w_raw, GRID_COLS);
        map_h  = clamp_size(h_raw, GRID_ROWS);
    endtask

    // Writes give no result, so a short pause covers one still in flight.
    task automatic drain();
        while (req_backlog.size() > 0 || req_if.valid || replies_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int w_raw, int h_raw, bit prefill, int count, int dens);
        set_map(w_raw, h_raw);
        if (prefill) fill_map(dens);
        random_reqs(count, dens);
        drain();
    endtask

    always @(negedge i_clk) begin : feed_requests
        t_cave_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (req_backlog.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = req_backlog.pop_front();
                req_if.valid       <= 1'b1;
                req_if.op          <= nxt.op;
                req_if.col         <= nxt.col;
                req_if.row         <= nxt.row;
                req_if.cell_in     <= nxt.val;
                req_if.rule_select <= nxt.rule;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (hold_phase && !hold_used) begin
            hold_left    <= HOLD_CYCLES;
            hold_used    <= 1'b1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : watch_ports
        t_cave_req q;
        t_cave_rsp due;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            q.op   = req_if.op;
            q.col  = req_if.col;
            q.row  = req_if.row;
            q.val  = req_if.cell_in;
            q.rule = req_if.rule_select;
            predict_reply(q);
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (replies_due.size() == 0) begin
                flag_mismatch($sformatf("result with nothing awaited: kind %0b cell %0b",
                                        rsp_if.result_kind, rsp_if.cell_out));
            end else begin
                due = replies_due.pop_front();
                if (rsp_if.result_kind !== due.kind)
                    flag_mismatch($sformatf("result_kind %0b, awaited %0b",
                                            rsp_if.result_kind, due.kind));
                if (rsp_if.cell_out !== due.val)
                    flag_mismatch($sformatf("cell_out %0b, awaited %0b",
                                            rsp_if.cell_out, due.val));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cfg_we             = 1'b0;
        cfg_addr           = CFG_MAP_WIDTH;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.op          = OP_WRITE;
        req_if.col         = '0;
        req_if.row         = '0;
        req_if.cell_in     = 1'b0;
        req_if.rule_select = 1'b0;
        rsp_if.ready       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full-size map after reset: the corners, then the unused op.
        push_req(OP_WRITE, 0, 0, CELL_WALL, RULE_SMOOTH);
        push_req(OP_WRITE, 63, 63, CELL_FLOOR, RULE_CONSERVATIVE);
        push_req(OP_WRITE, 63, 0, CELL_WALL, RULE_CONSERVATIVE);
        push_req(OP_WRITE, 0, 63, CELL_FLOOR, RULE_SMOOTH);
        push_req(OP_READ, 0, 0, CELL_FLOOR, RULE_CONSERVATIVE);
        push_req(OP_READ, 63, 63, CELL_WALL, RULE_SMOOTH);
        push_req(OP_READ, 63, 0, CELL_FLOOR, RULE_SMOOTH);
        push_req(OP_READ, 0, 63, CELL_WALL, RULE_CONSERVATIVE);
        push_req(OP_SPARE, 63, 63, CELL_WALL, RULE_SMOOTH);
        push_req(OP_WRITE, 63, 63, CELL_WALL, RULE_SMOOTH);
        push_req(OP_READ, 63, 63, CELL_FLOOR, RULE_CONSERVATIVE);
        drain();

        // A size of zero acts as a single cell surrounded by walls.
        set_map(0, 0);
        push_req(OP_WRITE, 0, 0, CELL_FLOOR, RULE_CONSERVATIVE);
        push_req(OP_GEN, 0, 0, CELL_FLOOR, RULE_SMOOTH);
        push_req(OP_READ, 0, 0, CELL_FLOOR, RULE_CONSERVATIVE);
        push_req(OP_GEN, 0, 0, CELL_FLOOR, RULE_CONSERVATIVE);
        push_req(OP_READ, 0, 0, CELL_FLOOR, RULE_CONSERVATIVE);
        push_req(OP_WRITE, 1, 0, CELL_FLOOR, RULE_CONSERVATIVE);
        push_req(OP_READ, 1, 0, CELL_FLOOR, RULE_CONSERVATIVE);
        push_req(OP_READ, 0, 1, CELL_FLOOR, RULE_SMOOTH);
        push_req(OP_WRITE, 0, 0, CELL_FLOOR, RULE_SMOOTH);
        push_req(OP_GEN, 0, 0, CELL_WALL, RULE_CONSERVATIVE);
        push_req(OP_READ, 0, 0, CELL_FLOOR, RULE_SMOOTH);
        drain();

        run_phase(127, 1, 1'b1, 25, 45);
        run_phase(1, 64, 1'b1, 25, 45);
        run_phase(64, 2, 1'b1, 25, 50);
        // A sparse map, so that lonely floors turn into walls.
        run_phase(5, 5, 1'b1, 30, 5);
        steady = 1'b1;
        run_phase(12, 7, 1'b1, 50, 50);
        steady = 1'b0;
        run_phase(8, 8, 1'b1, 45, 40);
        // Full map left partly unwritten; the receiver stalls for a long stretch.
        hold_phase = 1'b1;
        run_phase(64, 64, 1'b0, 80, 50);
        hold_phase = 1'b0;
        run_phase(3, 9, 1'b1, 35, 55);
        run_phase(16, 16, 1'b1, 40, 45);
        run_phase(2, 100, 1'b1, 20, 50);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", replies_due.size()));
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
